@@ hw/rtl/pmct_pkg.sv @@
`default_nettype none
package pmct_pkg;

    localparam int unsigned DimW     = 13;   // screen extent register width
    localparam int unsigned CoordW   = 12;   // cursor coordinate width
    localparam int unsigned BtnW     = 3;    // left, right, middle
    localparam int unsigned ByteW    = 8;

    localparam logic [DimW-1:0] WidthRst  = 13'd640;
    localparam logic [DimW-1:0] HeightRst = 13'd480;
    localparam logic [DimW-1:0] XMargin   = 13'd2;
    localparam logic [DimW-1:0] YMargin   = 13'd20;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QPtrW      = 1;
    localparam int unsigned QCntW      = 2;

    // register index on the config port (paddr[2])
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    // one word handed from the packet assembler to the cursor engine
    typedef struct packed {
        logic             is_pkt;   // word completed a packet
        logic [BtnW-1:0]  btn;      // button bits of byte 0
        logic [ByteW-1:0] dx;
        logic [ByteW-1:0] dy;
    } t_cmd;

endpackage
`default_nettype wire

@@ hw/rtl/pmct_front.sv @@
`default_nettype none
module pmct_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    input  wire logic                    i_aux,
    input  wire logic [pmct_pkg::ByteW-1:0] i_byte,
    input  wire logic                    i_q_full,
    output logic                         o_ready,
    output logic                         o_push,
    output pmct_pkg::t_cmd               o_cmd
);

    logic [1:0]                   r_pos;
    logic [1:0]                   n_pos;
    logic [pmct_pkg::BtnW-1:0]    r_b0;
    logic [pmct_pkg::ByteW-1:0]   r_b1;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        n_pos         = r_pos;
        o_cmd.is_pkt  = 1'b0;
        o_cmd.btn     = r_b0;
        o_cmd.dx      = r_b1;
        o_cmd.dy      = i_byte;
        if (i_aux) begin
            if (r_pos == 2'd2) begin
                n_pos        = 2'd0;
                o_cmd.is_pkt = 1'b1;
            end else begin
                n_pos = r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else if (o_push) begin
            r_pos <= n_pos;
        end
    end

    // packet bytes: no reset, always written before a packet completes
    always_ff @(posedge i_clk) begin
        if (o_push && i_aux) begin
            if (r_pos == 2'd0) begin
                r_b0 <= i_byte[pmct_pkg::BtnW-1:0];
            end
            if (r_pos == 2'd1) begin
                r_b1 <= i_byte;
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/pmct_queue.sv @@
`default_nettype none
module pmct_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pmct_pkg::t_cmd i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output pmct_pkg::t_cmd      o_cmd
);

    pmct_pkg::t_cmd                 r_mem [pmct_pkg::QueueDepth];
    logic [pmct_pkg::QPtrW-1:0]     r_wr_ptr;
    logic [pmct_pkg::QPtrW-1:0]     r_rd_ptr;
    logic [pmct_pkg::QCntW-1:0]     r_count;
    logic                           do_pop;

    assign o_full  = (r_count == pmct_pkg::QCntW'(pmct_pkg::QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/pmct_back.sv @@
`default_nettype none
module pmct_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [pmct_pkg::DimW-1:0]  i_width,
    input  wire logic [pmct_pkg::DimW-1:0]  i_height,
    input  wire logic                       i_q_valid,
    input  wire pmct_pkg::t_cmd             i_cmd,
    output logic                            o_pop,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_done,
    output logic [pmct_pkg::CoordW-1:0]     o_x,
    output logic [pmct_pkg::CoordW-1:0]     o_y,
    output logic [pmct_pkg::BtnW-1:0]       o_pressed,
    output logic [pmct_pkg::BtnW-1:0]       o_released,
    output logic                            o_press
);

    function automatic logic [pmct_pkg::CoordW-1:0] clamp_axis(
        input logic [pmct_pkg::CoordW-1:0] pos,
        input logic signed [13:0]          delta,
        input logic [pmct_pkg::DimW-1:0]   extent,
        input logic [pmct_pkg::DimW-1:0]   margin
    );
        logic signed [13:0] lim;
        logic signed [13:0] np;
        lim = $signed({1'b0, extent}) - $signed({1'b0, margin});
        if (lim < 14'sd0) lim = 14'sd0;
        if (lim > 14'sd4095) lim = 14'sd4095;
        np = $signed({2'b00, pos}) + delta;
        if (np < 14'sd0) np = 14'sd0;
        if (np >= lim) np = lim;
        return np[pmct_pkg::CoordW-1:0];
    endfunction

    logic [pmct_pkg::CoordW-1:0] r_pos_x, n_pos_x;
    logic [pmct_pkg::CoordW-1:0] r_pos_y, n_pos_y;
    logic [pmct_pkg::BtnW-1:0]   r_prev, n_prev;
    logic                        r_press, n_press;
    logic [pmct_pkg::BtnW-1:0]   changed, pmask, rmask;
    logic signed [13:0]          dx_s, dy_n;
    logic                        r_out_valid;

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        dx_s    = $signed({{6{i_cmd.dx[7]}}, i_cmd.dx});
        dy_n    = 14'sd0 - $signed({{6{i_cmd.dy[7]}}, i_cmd.dy});
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_prev  = r_prev;
        n_press = r_press;
        changed = i_cmd.btn ^ r_prev;
        pmask   = '0;
        rmask   = '0;
        if (i_cmd.is_pkt) begin
            if (i_cmd.dx != '0 || i_cmd.dy != '0) begin
                n_pos_x = clamp_axis(r_pos_x, dx_s, i_width, pmct_pkg::XMargin);
                n_pos_y = clamp_axis(r_pos_y, dy_n, i_height, pmct_pkg::YMargin);
            end
            pmask  = changed & i_cmd.btn;
            rmask  = changed & r_prev;
            n_prev = i_cmd.btn;
            // highest changed button decides
            for (int i = 0; i < pmct_pkg::BtnW; i++) begin
                if (changed[i]) begin
                    n_press = i_cmd.btn[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_prev      <= '0;
            r_press     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_prev      <= n_prev;
                r_press     <= n_press;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_done     <= i_cmd.is_pkt;
            o_x        <= n_pos_x;
            o_y        <= n_pos_y;
            o_pressed  <= pmask;
            o_released <= rmask;
            o_press    <= n_press;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ps2_mouse_packet_cursor_tracker.sv @@
// Channel    Dir  Handshake                    Payload
// s_axis     in   s_axis_tvalid/tready         tdata = data_byte, tuser = aux_ready
// m_axis     out  m_axis_tvalid/tready         tdata = cursor/buttons, tlast = packet_done
// apb        in   psel/penable/pwrite/pready   0x0 screen_width, 0x4 screen_height
//
// One word in, one word out, one word per cycle sustained while m_axis_tready stays high.
// The path is registered: a word accepted sits in the queue, is then popped
// into the output register and can leave from there.
// The assembler and the cursor engine meet through a two-entry queue, so with
// the output register held by a stalled m_axis two more words get in before
// s_axis_tready drops.
// Synchronous active-low reset clears byte position, cursor, buttons, queue
// and reloads the 640x480 screen.
`default_nettype none
module ps2_mouse_packet_cursor_tracker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] aux_ready
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [11:0] cursor_x, [23:12] cursor_y,
                                             // [26:24] pressed_mask,
                                             // [29:27] released_mask,
                                             // [30] press_flag, [31] zero
    output logic             m_axis_tlast,   // packet_done
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [pmct_pkg::DimW-1:0]   r_width;
    logic [pmct_pkg::DimW-1:0]   r_height;
    pmct_pkg::t_reg_idx          reg_idx;

    logic                        push;
    logic                        q_full;
    logic                        q_valid;
    logic                        pop;
    pmct_pkg::t_cmd              cmd_in;
    pmct_pkg::t_cmd              cmd_out;

    logic                        done;
    logic [pmct_pkg::CoordW-1:0] cur_x;
    logic [pmct_pkg::CoordW-1:0] cur_y;
    logic [pmct_pkg::BtnW-1:0]   pressed;
    logic [pmct_pkg::BtnW-1:0]   released;
    logic                        press;

    // ---- config registers: word address in paddr[2], byte lanes ignored
    assign pready  = 1'b1;
    assign reg_idx = pmct_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pmct_pkg::WidthRst;
            r_height <= pmct_pkg::HeightRst;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                pmct_pkg::REG_WIDTH:  r_width  <= pwdata[pmct_pkg::DimW-1:0];
                pmct_pkg::REG_HEIGHT: r_height <= pwdata[pmct_pkg::DimW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            pmct_pkg::REG_WIDTH:  prdata = {19'd0, r_width};
            pmct_pkg::REG_HEIGHT: prdata = {19'd0, r_height};
            default:              prdata = '0;
        endcase
    end

    // ---- front: gathers flagged bytes into packets, tags each word
    pmct_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_aux    (s_axis_tuser),
        .i_byte   (s_axis_tdata),
        .i_q_full (q_full),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_cmd    (cmd_in)
    );

    pmct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (cmd_out)
    );

    // ---- back: cursor move, clamp, button edges, output register
    pmct_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_q_valid   (q_valid),
        .i_cmd       (cmd_out),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_done      (done),
        .o_x         (cur_x),
        .o_y         (cur_y),
        .o_pressed   (pressed),
        .o_released  (released),
        .o_press     (press)
    );

    assign m_axis_tdata = {1'b0, press, released, pressed, cur_y, cur_x};
    assign m_axis_tlast = done;

endmodule
`default_nettype wire
